// ----- src/phx_pkg.sv -----
// ----------------------------------------------------------------------------
// phx_pkg
// shared widths, accumulator memory map and feature order table
// ----------------------------------------------------------------------------
package phx_pkg;

    localparam int GRID_SIDE     = 8;
    localparam int CELL_BITS     = 8;
    localparam int ACC_BITS      = 14;
    localparam int SUM_BITS      = ACC_BITS + 1;
    localparam int ADDR_BITS     = 6;
    localparam int IDX_BITS      = 6;
    localparam int FEATURE_COUNT = 43;
    localparam int CELL_COUNT    = GRID_SIDE * GRID_SIDE;
    localparam int MEM_DEPTH     = 1 << ADDR_BITS;

    localparam logic [IDX_BITS-1:0]  LAST_INDEX = IDX_BITS'(FEATURE_COUNT - 1);
    localparam logic [ADDR_BITS-1:0] LAST_CELL  = ADDR_BITS'(CELL_COUNT - 1);
    localparam logic [ADDR_BITS-1:0] LAST_ADDR  = ADDR_BITS'(MEM_DEPTH - 1);

    // accumulator memory map
    localparam logic [ADDR_BITS-1:0] ROW_BASE   = 6'd0;
    localparam logic [ADDR_BITS-1:0] COL_BASE   = 6'd8;
    localparam logic [ADDR_BITS-1:0] RISE_BASE  = 6'd16;
    localparam logic [ADDR_BITS-1:0] FALL_BASE  = 6'd32;
    localparam logic [ADDR_BITS-1:0] QUAD_BASE  = 6'd48;
    localparam logic [ADDR_BITS-1:0] TOTAL_ADDR = 6'd52;

    localparam logic [ACC_BITS-1:0] LINE_MAX  = 14'd2047;
    localparam logic [ACC_BITS-1:0] QUAD_MAX  = 14'd4095;
    localparam logic [ACC_BITS-1:0] TOTAL_MAX = 14'd16383;

    typedef struct packed {
        logic                push;
        logic [IDX_BITS-1:0] index;
        logic [ACC_BITS-1:0] value;
    } phx_push_t;

    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } phx_fifo_stat_t;

    // saturation limit of the accumulator stored at an address
    function automatic logic [ACC_BITS-1:0] sat_max(input logic [ADDR_BITS-1:0] addr);
        logic [ACC_BITS-1:0] m;
        if (addr < QUAD_BASE)
            m = LINE_MAX;
        else if (addr < TOTAL_ADDR)
            m = QUAD_MAX;
        else
            m = TOTAL_MAX;
        return m;
    endfunction

    // memory address of each feature in output order
    function automatic logic [ADDR_BITS-1:0] emit_addr(input logic [IDX_BITS-1:0] e);
        logic [7:0] ex;
        logic [7:0] a;
        ex = {2'b00, e};
        case (e) inside
            [6'd0:6'd6]:   a = ex;
            [6'd7:6'd13]:  a = ex + 8'd1;
            [6'd14:6'd25]: a = 8'd42 - ex;
            [6'd26:6'd32]: a = 8'd71 - ex;
            [6'd33:6'd37]: a = 8'd70 - ex;
            [6'd38:6'd41]: a = ex + 8'd10;
            default:       a = {2'b00, TOTAL_ADDR};
        endcase
        return a[ADDR_BITS-1:0];
    endfunction

endpackage

// ----- src/projection_histogram_features.sv -----
// ----------------------------------------------------------------------------
// projection_histogram_features
// projection histogram features of an 8x8 cell grid
//
// cells enter on the cell channel (cell_value, cell_valid, cell_ready) in
// row-major order, one transfer per cell. each cell is folded into six
// accumulators (row, column, both diagonals, quadrant, total) held in one
// 64-word memory, one read-modify-write per memory cycle; cell_ready stays
// low until the last of the six has been issued.
// after the 64th cell the 43 features leave on the feature channel
// (feature_index, feature_value, last_feature, feature_valid, feature_ready),
// at most one per cycle, and last_feature marks index 42, the total, an
// unsigned integer. a sweep over all 64 words then zeroes the memory
// before the next image; after reset the same sweep runs with
// cell_ready low.
// a stalled receiver fills the two-entry output queue and pauses the
// readout; nothing is lost.
// ----------------------------------------------------------------------------
module projection_histogram_features
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [7:0]                   cell_value,
    input  logic                         cell_valid,
    output logic                         cell_ready,
    output logic [phx_pkg::IDX_BITS-1:0] feature_index,
    output logic [phx_pkg::ACC_BITS-1:0] feature_value,
    output logic                         last_feature,
    output logic                         feature_valid,
    input  logic                         feature_ready
);
    import phx_pkg::*;

    phx_push_t      push;
    phx_fifo_stat_t stat;

    phx_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_value (cell_value),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .stat       (stat),
        .push_out   (push)
    );

    phx_out_fifo u_out_fifo
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push_in       (push),
        .stat          (stat),
        .feature_valid (feature_valid),
        .feature_ready (feature_ready),
        .feature_index (feature_index),
        .feature_value (feature_value)
    );

    assign last_feature = (feature_index == LAST_INDEX);

endmodule

// ----- src/phx_out_fifo.sv -----
// ----------------------------------------------------------------------------
// phx_out_fifo
// two-entry output queue that holds features until the receiver takes them
// ----------------------------------------------------------------------------
module phx_out_fifo
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  phx_pkg::phx_push_t                push_in,
    output phx_pkg::phx_fifo_stat_t           stat,
    output logic                              feature_valid,
    input  logic                              feature_ready,
    output logic [phx_pkg::IDX_BITS-1:0]      feature_index,
    output logic [phx_pkg::ACC_BITS-1:0]      feature_value
);
    import phx_pkg::*;

    logic [IDX_BITS-1:0] idx_reg [2];
    logic [ACC_BITS-1:0] val_reg [2];
    logic                wr_ptr_reg;
    logic                wr_ptr_next;
    logic                rd_ptr_reg;
    logic                rd_ptr_next;
    logic [1:0]          count_reg;
    logic [1:0]          count_next;
    logic                pop;

    assign feature_valid = (count_reg != 2'd0);
    assign pop           = feature_valid && feature_ready;
    assign feature_index = idx_reg[rd_ptr_reg];
    assign feature_value = val_reg[rd_ptr_reg];
    assign stat.count    = count_reg;
    assign stat.pop      = pop;

    always_comb
    begin
        wr_ptr_next = push_in.push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push_in.push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_in.push)
        begin
            idx_reg[wr_ptr_reg] <= push_in.index;
            val_reg[wr_ptr_reg] <= push_in.value;
        end
    end

endmodule

// ----- src/phx_core.sv -----
// ----------------------------------------------------------------------------
// phx_core
// accumulator memory with read-modify-write sequencer, feature readout
// and clearing sweep
// ----------------------------------------------------------------------------
module phx_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [7:0]                        cell_value,
    input  logic                              cell_valid,
    output logic                              cell_ready,
    input  phx_pkg::phx_fifo_stat_t           stat,
    output phx_pkg::phx_push_t                push_out
);
    import phx_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_ACC   = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    localparam logic [2:0] STEP_FIRST = 3'd1;
    localparam logic [2:0] STEP_LAST  = 3'd5;

    logic [ACC_BITS-1:0]  acc_mem [MEM_DEPTH];

    state_t               state_reg;
    state_t               state_next;
    logic [ADDR_BITS-1:0] pos_reg;
    logic [ADDR_BITS-1:0] pos_next;
    logic [2:0]           step_reg;
    logic [2:0]           step_next;
    logic [IDX_BITS-1:0]  emit_cnt_reg;
    logic [IDX_BITS-1:0]  emit_cnt_next;
    logic [ADDR_BITS-1:0] clr_cnt_reg;
    logic [ADDR_BITS-1:0] clr_cnt_next;
    logic                 rmw_reg;
    logic                 emit_q_reg;
    logic [ADDR_BITS-1:0] rmw_addr_reg;
    logic [IDX_BITS-1:0]  emit_idx_reg;
    logic [CELL_BITS-1:0] value_reg;
    logic [ACC_BITS-1:0]  rd_data_reg;

    logic                 accept;
    logic                 rd_en;
    logic                 rd_rmw;
    logic                 rd_emit;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 clr_we;
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic [ACC_BITS-1:0]  wdata;
    logic [SUM_BITS-1:0]  sum;
    logic [ACC_BITS-1:0]  limit;
    logic [ACC_BITS-1:0]  sat_val;
    logic                 credit;
    logic [2:0]           row;
    logic [2:0]           col;
    logic [ADDR_BITS-1:0] step_addr;
    logic [3:0]           rise_idx;
    logic [3:0]           fall_idx;

    assign row        = pos_reg[5:3];
    assign col        = pos_reg[2:0];
    assign rise_idx   = {1'b0, row} + {1'b0, col};
    assign fall_idx   = {1'b0, col} + 4'd7 - {1'b0, row};
    assign cell_ready = (state_reg == S_IDLE);
    assign accept     = cell_valid && cell_ready;

    // room for one more readout word, counting the one in flight
    assign credit = (3'(stat.count) + 3'(emit_q_reg)) < (3'd2 + 3'(stat.pop));

    always_comb
    begin
        case (step_reg)
            3'd1:    step_addr = COL_BASE + ADDR_BITS'(col);
            3'd2:    step_addr = RISE_BASE + ADDR_BITS'(rise_idx);
            3'd3:    step_addr = FALL_BASE + ADDR_BITS'(fall_idx);
            3'd4:    step_addr = QUAD_BASE + ADDR_BITS'({row[2], col[2]});
            default: step_addr = TOTAL_ADDR;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        step_next     = step_reg;
        emit_cnt_next = emit_cnt_reg;
        clr_cnt_next  = clr_cnt_reg;
        rd_en         = 1'b0;
        rd_rmw        = 1'b0;
        rd_emit       = 1'b0;
        rd_addr       = ROW_BASE + ADDR_BITS'(row);
        clr_we        = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + ADDR_BITS'(1);
                if (clr_cnt_reg == LAST_ADDR)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                rd_en  = 1'b1;
                rd_rmw = accept;
                if (accept)
                begin
                    step_next  = STEP_FIRST;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                rd_en   = 1'b1;
                rd_rmw  = 1'b1;
                rd_addr = step_addr;
                if (step_reg == STEP_LAST)
                begin
                    pos_next      = pos_reg + ADDR_BITS'(1);
                    emit_cnt_next = '0;
                    state_next    = (pos_reg == LAST_CELL) ? S_EMIT : S_IDLE;
                end
                else
                    step_next = step_reg + 3'd1;
            end
            S_EMIT:
            begin
                rd_addr = emit_addr(emit_cnt_reg);
                if (credit)
                begin
                    rd_en         = 1'b1;
                    rd_emit       = 1'b1;
                    emit_cnt_next = emit_cnt_reg + IDX_BITS'(1);
                    if (emit_cnt_reg == LAST_INDEX)
                    begin
                        clr_cnt_next = '0;
                        state_next   = S_CLEAR;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // write-back of the word read in the previous cycle, or a zero from the clearing sweep
    always_comb
    begin
        sum     = {1'b0, rd_data_reg} + SUM_BITS'(value_reg);
        limit   = sat_max(rmw_addr_reg);
        sat_val = (sum > SUM_BITS'(limit)) ? limit : sum[ACC_BITS-1:0];
        we      = rmw_reg || clr_we;
        waddr   = clr_we ? clr_cnt_reg : rmw_addr_reg;
        wdata   = clr_we ? '0 : sat_val;
    end

    assign push_out.push  = emit_q_reg;
    assign push_out.index = emit_idx_reg;
    assign push_out.value = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            pos_reg      <= '0;
            step_reg     <= STEP_FIRST;
            emit_cnt_reg <= '0;
            clr_cnt_reg  <= '0;
            rmw_reg      <= 1'b0;
            emit_q_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            step_reg     <= step_next;
            emit_cnt_reg <= emit_cnt_next;
            clr_cnt_reg  <= clr_cnt_next;
            rmw_reg      <= rd_en && rd_rmw;
            emit_q_reg   <= rd_en && rd_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            value_reg <= cell_value[CELL_BITS-1:0];
        if (rd_en)
        begin
            rmw_addr_reg <= rd_addr;
            emit_idx_reg <= emit_cnt_reg;
        end
    end

    // accumulator memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
            acc_mem[waddr] <= wdata;
        if (rd_en)
            rd_data_reg <= acc_mem[rd_addr];
    end

endmodule

// ----- test/projection_histogram_features_test.sv -----
// ----------------------------------------------------------------------------
// projection_histogram_features_test
// self-checking bench for the 8x8 projection histogram feature block
//
// whole frames of 64 cells are sent over the cell channel; a predictor folds
// every accepted cell into its own row, column, diagonal, quadrant and total
// sums and queues the 43 features each frame must produce. every feature
// transfer is compared field by field with the oldest queued feature. frames
// run under three idling patterns: a slow receiver, a slow sender, and none.
// ----------------------------------------------------------------------------
module projection_histogram_features_test;

    import phx_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 120;
    localparam int MAX_GAP      = 40;

    typedef struct packed {
        logic [IDX_BITS-1:0] index;
        logic [ACC_BITS-1:0] value;
        logic                last;
    } feature_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic [7:0]          cell_value    = 8'd0;
    logic                cell_valid    = 1'b0;
    logic                cell_ready;
    logic [IDX_BITS-1:0] feature_index;
    logic [ACC_BITS-1:0] feature_value;
    logic                last_feature;
    logic                feature_valid;
    logic                feature_ready = 1'b0;

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int mismatches        = 0;
    int quiet_cycles      = 0;

    // predictor state
    logic [ADDR_BITS-1:0] cell_pos;
    logic [ACC_BITS-1:0]  row_acc  [GRID_SIDE];
    logic [ACC_BITS-1:0]  col_acc  [GRID_SIDE];
    logic [ACC_BITS-1:0]  rise_acc [2*GRID_SIDE-1];
    logic [ACC_BITS-1:0]  fall_acc [2*GRID_SIDE-1];
    logic [ACC_BITS-1:0]  quad_acc [4];
    logic [ACC_BITS-1:0]  total_acc;
    logic [IDX_BITS-1:0]  next_index;
    feature_t             expected_features[$];

    projection_histogram_features i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cell_value    (cell_value),
        .cell_valid    (cell_valid),
        .cell_ready    (cell_ready),
        .feature_index (feature_index),
        .feature_value (feature_value),
        .last_feature  (last_feature),
        .feature_valid (feature_valid),
        .feature_ready (feature_ready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        feature_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((cell_valid && cell_ready) || (feature_valid && feature_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_feature
        feature_t want;
        if (rst_n && feature_valid && feature_ready)
        begin
            if (expected_features.size() == 0)
                report_mismatch($sformatf("feature %0d with none expected", feature_index));
            else
            begin
                want = expected_features.pop_front();
                if (feature_index !== want.index)
                    report_mismatch($sformatf("feature_index %0d, expected %0d",
                                              feature_index, want.index));
                if (feature_value !== want.value)
                    report_mismatch($sformatf("feature %0d value %0d, expected %0d",
                                              want.index, feature_value, want.value));
                if (last_feature !== want.last)
                    report_mismatch($sformatf("feature %0d last_feature %b, expected %b",
                                              want.index, last_feature, want.last));
            end
        end
    end

    function automatic logic [ACC_BITS-1:0] sat_sum(input logic [ACC_BITS-1:0] acc,
                                                    input logic [7:0]          v,
                                                    input logic [ACC_BITS-1:0] lim);
        logic [ACC_BITS:0] s;
        s = {1'b0, acc} + (ACC_BITS+1)'(v);
        return (s > {1'b0, lim}) ? lim : s[ACC_BITS-1:0];
    endfunction

    function automatic void clear_sums();
        cell_pos   = '0;
        next_index = '0;
        total_acc  = '0;
        foreach (row_acc[i])  row_acc[i]  = '0;
        foreach (col_acc[i])  col_acc[i]  = '0;
        foreach (rise_acc[i]) rise_acc[i] = '0;
        foreach (fall_acc[i]) fall_acc[i] = '0;
        foreach (quad_acc[i]) quad_acc[i] = '0;
    endfunction

    function automatic void queue_feature(input logic [ACC_BITS-1:0] v);
        feature_t f;
        f.index = next_index;
        f.value = v;
        f.last  = (next_index == LAST_INDEX);
        expected_features.insert(expected_features.size(), f);
        next_index++;
    endfunction

    // fold one accepted cell into the sums, queue the vector on the last cell
    function automatic void fold_cell(input logic [7:0] v);
        int r;
        int c;
        int q;
        r = cell_pos / GRID_SIDE;
        c = cell_pos % GRID_SIDE;
        q = 2 * (r / 4) + c / 4;
        row_acc[r]          = sat_sum(row_acc[r], v, LINE_MAX);
        col_acc[c]          = sat_sum(col_acc[c], v, LINE_MAX);
        rise_acc[r + c]     = sat_sum(rise_acc[r + c], v, LINE_MAX);
        fall_acc[c - r + 7] = sat_sum(fall_acc[c - r + 7], v, LINE_MAX);
        quad_acc[q]         = sat_sum(quad_acc[q], v, QUAD_MAX);
        total_acc           = sat_sum(total_acc, v, TOTAL_MAX);
        if (cell_pos != LAST_CELL)
            cell_pos++;
        else
        begin
            for (int d = 0; d < 7; d++)
                queue_feature(row_acc[d]);
            for (int d = 0; d < 7; d++)
                queue_feature(col_acc[d]);
            for (int d = 12; d >= 1; d--)
                queue_feature(rise_acc[d]);
            for (int d = 6; d >= 0; d--)
                queue_feature(fall_acc[d + 7]);
            for (int d = -2; d >= -6; d--)
                queue_feature(fall_acc[d + 7]);
            for (int d = 0; d < 4; d++)
                queue_feature(quad_acc[d]);
            queue_feature(total_acc);
            clear_sums();
        end
    endfunction

    // one cell transfer, with a random idle gap in front
    task automatic send_cell(input logic [7:0] v);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            cell_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cell_valid <= 1'b1;
        cell_value <= v;
        do
            @(posedge clk);
        while (!cell_ready);
        fold_cell(v);
    endtask

    task automatic wait_drained();
        cell_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_features.size() != 0);
    endtask

    function automatic logic [7:0] random_cell();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return 8'($urandom_range(255));
        else if (pick < 70)
            return 8'd0;
        else if (pick < 85)
            return 8'hFF;
        else
            return 8'(1 << $urandom_range(7));
    endfunction

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct   = sender_pct;
        receiver_idle_pct = receiver_pct;
    endtask

    // every cell at full scale: largest line, quadrant and total sums
    task automatic test_full_scale_frame();
        repeat (CELL_COUNT) send_cell(8'hFF);
    endtask

    // a distinct value per cell position catches swapped rows, columns or diagonals
    task automatic test_position_map();
        for (int p = 0; p < CELL_COUNT; p++)
            send_cell(8'((p * 37 + 11) & 8'hFF));
    endtask

    task automatic test_random_frame();
        repeat (CELL_COUNT) send_cell(random_cell());
    endtask

    // sender holds off until the whole vector is out, then starts a new frame
    task automatic test_restart_after_drain();
        wait_drained();
        test_random_frame();
    endtask

    initial
    begin
        clear_sums();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(18, 70);
        test_full_scale_frame();

        set_idling(70, 18);
        test_restart_after_drain();

        set_idling(0, 0);
        test_position_map();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
src/phx_pkg.sv
src/phx_out_fifo.sv
src/phx_core.sv
src/projection_histogram_features.sv
test/projection_histogram_features_test.sv
